[sv/hmn_pkg.sv]
// shared constants of the height map to normal map block
package hmn_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SLOPE_GAIN   = 2'd2;

  // reset values of the registers
  localparam logic [12:0] WIDTH_RESET  = 13'd256;
  localparam logic [15:0] HEIGHT_RESET = 16'd256;
  localparam logic [23:0] GAIN_RESET   = 24'd65536;

  // unit z component, 16 fraction bits
  localparam logic [16:0] Z_ONE = 17'd65536;

  // one slope job waiting for the normal unit
  typedef struct packed {
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic [15:0]        row;
    logic               done;
  } slope_job_t;

endpackage

[sv/heightmap_normal_map.sv]
// height map to normal map: line buffer, slope setup and normal unit
// steps: a sample is taken and prepared, then each of its results (up to three)
// passes the multiply, 1 to 10 shift steps, the 32-step square root and three divides
// throughput: one sample at a time; a result waits in the output register
// rst is synchronous: counters, left samples and registers return to reset
// values; the line buffer holds undefined data until row 0 has written it
module heightmap_normal_map
  import hmn_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] height_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [11:0] pixel_column,
  output logic [15:0] pixel_row,
  output logic        run_last,
  output logic        frame_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int AW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int EW = AW + 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_MUL, ST_SHIFT, ST_SQ, ST_SQRT, ST_CMUL, ST_DIV, ST_OUT
  } state_t;

  state_t state;

  // registers
  logic [12:0] image_width;
  logic [15:0] image_height;
  logic [23:0] slope_gain;

  // frame position and left neighbours
  logic [AW-1:0] column_count;
  logic [15:0]   row_count;
  logic [15:0]   left_old_sample;
  logic [15:0]   left_new_sample;

  // current sample
  logic [AW-1:0] cur_c;
  logic [15:0]   cur_s;

  // line buffer
  logic [15:0]   row_store [MAX_WIDTH];
  logic [15:0]   rd_above;
  logic [15:0]   rd_right;
  logic          mem_rd;
  logic          mem_we;
  logic [AW-1:0] rd_addr;

  // effective geometry
  logic [EW-1:0] eff_w;
  logic [15:0]   eff_h;
  logic [AW-1:0] c_clamp;

  // job list
  slope_job_t    job [3];
  logic [AW-1:0] job_col [3];
  logic [1:0]    job_n;
  logic [1:0]    job_idx;
  slope_job_t    p_job [3];
  logic [AW-1:0] p_col [3];
  logic [1:0]    p_n;

  // normal unit
  logic [39:0] ax;
  logic [39:0] ay;
  logic [16:0] az;
  logic [1:0]  sel;
  logic [62:0] sum;
  logic [63:0] sq_rem;
  logic [63:0] sq_res;
  logic [63:0] sq_bit;
  logic [31:0] len;
  logic [41:0] drem;
  logic [2:0]  dcnt;
  logic [7:0]  quo;
  logic [7:0]  code_x;
  logic [7:0]  code_y;

  // combinational helpers
  slope_job_t    cj;
  logic [15:0]   mag_x;
  logic [15:0]   mag_y;
  logic [30:0]   sq_in;
  logic [63:0]   sq_try;
  logic [31:0]   comp_a;
  logic          comp_neg;
  logic [31:0]   comp_cl;
  logic [32:0]   comp_num;
  logic [41:0]   div_sh;
  logic [7:0]    quo_next;
  logic          c1_lt_w;
  logic signed [16:0] d_above;
  logic signed [16:0] dx_top;
  logic          has0;
  logic          has1;
  logic          has2;

  assign cfg_ready = (state == ST_IDLE);
  assign in_ready  = (state == ST_IDLE);

  // effective width, height and clamped column
  always_comb begin
    if (image_width < 13'd2) begin
      eff_w = EW'(2);
    end else if (int'(image_width) > MAX_WIDTH) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(image_width);
    end
    eff_h = (image_height < 16'd2) ? 16'd2 : image_height;
    if ({1'b0, column_count} >= eff_w) begin
      c_clamp = AW'(eff_w - EW'(1));
    end else begin
      c_clamp = column_count;
    end
  end

  assign mem_rd  = in_valid && in_ready;
  assign mem_we  = (state == ST_PREP);
  assign rd_addr = mem_rd ? c_clamp : cur_c;

  // line buffer, two read ports and one write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      row_store[cur_c] <= cur_s;
    end
    if (mem_rd) begin
      rd_above <= row_store[rd_addr];
      rd_right <= row_store[AW'(rd_addr + AW'(1))];
    end
  end

  // slope jobs of this sample
  always_comb begin
    slope_job_t ja;
    slope_job_t jb;
    slope_job_t jc;
    c1_lt_w = ({1'b0, cur_c} + EW'(1)) < eff_w;
    d_above = $signed({1'b0, cur_s}) - $signed({1'b0, rd_above});
    dx_top  = c1_lt_w ? ($signed({1'b0, rd_right}) - $signed({1'b0, rd_above}))
                      : ($signed({1'b0, rd_above}) - $signed({1'b0, left_old_sample}));
    has0 = (row_count != 16'd0);
    has1 = (row_count == eff_h - 16'd1) && (cur_c != '0);
    has2 = has1 && ({1'b0, cur_c} == eff_w - EW'(1));
    ja.dx = dx_top;
    ja.dy = d_above;
    ja.row = row_count - 16'd1;
    ja.done = 1'b0;
    jb.dx = $signed({1'b0, cur_s}) - $signed({1'b0, left_new_sample});
    jb.dy = $signed({1'b0, left_new_sample}) - $signed({1'b0, left_old_sample});
    jb.row = row_count;
    jb.done = 1'b0;
    jc.dx = jb.dx;
    jc.dy = d_above;
    jc.row = row_count;
    jc.done = 1'b1;
    if (has0) begin
      p_job[0] = ja;
      p_col[0] = cur_c;
      p_job[1] = jb;
      p_col[1] = cur_c - AW'(1);
      p_job[2] = jc;
      p_col[2] = cur_c;
    end else begin
      p_job[0] = jb;
      p_col[0] = cur_c - AW'(1);
      p_job[1] = jc;
      p_col[1] = cur_c;
      p_job[2] = jc;
      p_col[2] = cur_c;
    end
    p_n = 2'({1'b0, has0} + {1'b0, has1} + {1'b0, has2});
  end

  // datapath selects of the normal unit
  always_comb begin
    cj = job[job_idx];
    mag_x = cj.dx[16] ? 16'(-cj.dx) : cj.dx[15:0];
    mag_y = cj.dy[16] ? 16'(-cj.dy) : cj.dy[15:0];
    unique case (sel)
      2'd0:    sq_in = ax[30:0];
      2'd1:    sq_in = ay[30:0];
      default: sq_in = {14'd0, az};
    endcase
    sq_try = sq_res + sq_bit;
    unique case (sel)
      2'd0: begin
        comp_a = {1'b0, ax[30:0]};
        comp_neg = !cj.dx[16] && (cj.dx != '0);
      end
      2'd1: begin
        comp_a = {1'b0, ay[30:0]};
        comp_neg = cj.dy[16];
      end
      default: begin
        comp_a = {15'd0, az};
        comp_neg = 1'b0;
      end
    endcase
    comp_cl  = (comp_a > len) ? len : comp_a;
    comp_num = comp_neg ? 33'(len - comp_cl) : ({1'b0, len} + {1'b0, comp_cl});
    div_sh   = 42'({len, 1'b0}) << dcnt;
    quo_next = (drem >= div_sh) ? (quo | (8'd1 << dcnt)) : quo;
  end

  // control, counters and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      image_width <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      slope_gain <= GAIN_RESET;
      column_count <= '0;
      row_count <= '0;
      left_old_sample <= '0;
      left_new_sample <= '0;
      out_valid <= 1'b0;
      job_n <= '0;
      job_idx <= '0;
    end else begin
      // configuration writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH: begin
            image_width <= cfg_data[12:0];
            column_count <= '0;
            row_count <= '0;
          end
          REG_IMAGE_HEIGHT: begin
            image_height <= cfg_data[15:0];
            column_count <= '0;
            row_count <= '0;
          end
          REG_SLOPE_GAIN: slope_gain <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cur_c <= c_clamp;
            cur_s <= height_sample;
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          for (int i = 0; i < 3; i++) begin
            job[i] <= p_job[i];
            job_col[i] <= p_col[i];
          end
          job_n <= p_n;
          job_idx <= '0;
          left_old_sample <= rd_above;
          left_new_sample <= cur_s;
          if (!c1_lt_w) begin
            column_count <= '0;
            row_count <= ({1'b0, row_count} + 17'd1 >= {1'b0, eff_h}) ? 16'd0
                         : row_count + 16'd1;
          end else begin
            column_count <= cur_c + AW'(1);
          end
          state <= (p_n == 2'd0) ? ST_IDLE : ST_MUL;
        end
        ST_MUL: begin
          ax <= 40'(mag_x * slope_gain);
          ay <= 40'(mag_y * slope_gain);
          az <= Z_ONE;
          state <= ST_SHIFT;
        end
        ST_SHIFT: begin
          // bring the largest slope below 2^31
          if ((ax[39:31] != '0) || (ay[39:31] != '0)) begin
            ax <= ax >> 1;
            ay <= ay >> 1;
            az <= az >> 1;
          end else begin
            sel <= 2'd0;
            sum <= '0;
            state <= ST_SQ;
          end
        end
        ST_SQ: begin
          sum <= sum + 63'(sq_in * sq_in);
          if (sel == 2'd2) begin
            state <= ST_SQRT;
            sq_res <= '0;
            sq_bit <= 64'd1 << 62;
            sq_rem <= {1'b0, sum + 63'(sq_in * sq_in)};
          end else begin
            sel <= sel + 2'd1;
          end
        end
        ST_SQRT: begin
          // one result bit per cycle
          if (sq_rem >= sq_try) begin
            sq_rem <= sq_rem - sq_try;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          if (sq_bit == 64'd1) begin
            len <= (sq_rem >= sq_try) ? 32'((sq_res >> 1) + sq_bit) : 32'(sq_res >> 1);
            sel <= 2'd0;
            state <= ST_CMUL;
          end
        end
        ST_CMUL: begin
          drem <= 42'(comp_num * 9'd255);
          dcnt <= 3'd7;
          quo <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          // restoring divide by twice the length
          if (drem >= div_sh) begin
            drem <= drem - div_sh;
          end
          quo <= quo_next;
          dcnt <= dcnt - 3'd1;
          if (dcnt == 3'd0) begin
            unique case (sel)
              2'd0: begin
                code_x <= quo_next;
                sel <= 2'd1;
                state <= ST_CMUL;
              end
              2'd1: begin
                code_y <= quo_next;
                sel <= 2'd2;
                state <= ST_CMUL;
              end
              default: begin
                red <= code_x;
                green <= code_y;
                blue <= quo_next;
                pixel_column <= 12'(job_col[job_idx]);
                pixel_row <= cj.row;
                run_last <= (job_idx == job_n - 2'd1);
                frame_done <= cj.done;
                out_valid <= 1'b1;
                state <= ST_OUT;
              end
            endcase
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (job_idx == job_n - 2'd1) begin
              state <= ST_IDLE;
            end else begin
              job_idx <= job_idx + 2'd1;
              state <= ST_MUL;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // one sample at a time: no item taken while a result is shown
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("input taken while a result is pending");

  // the frame's final pixel closes its sample's run
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> run_last)
    else $error("frame_done without run_last");

  // after the last result of a sample the block takes the next item
  a_back_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && run_last |=> in_ready)
    else $error("block not idle after last result");

endmodule
